/* rtl/npc_pkg.sv */
package npc_pkg;

    localparam int PIX_W            = 16;
    localparam int DEF_MAX_COLS     = 128;
    localparam int DEF_MAX_ROWS     = 1024;
    localparam int DEF_QUEUE_DEPTH  = 4;
    localparam int ROWS_CFG_W       = 11;
    localparam int COLS_CFG_W       = 8;
    localparam int CFG_DATA_W       = 11;
    localparam int CFG_INDEX_W      = 2;
    localparam int NUM_SLOTS        = 3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FRAME_ROWS = 2'd0,
        REG_FRAME_COLS = 2'd1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        SLOT_ABOVE = 2'd0,
        SLOT_LEFT  = 2'd1,
        SLOT_FINAL = 2'd2
    } slot_t;

    typedef struct packed {
        logic [NUM_SLOTS-1:0]            valid;
        logic [NUM_SLOTS-1:0][PIX_W-1:0] pix;
    } bundle_t;

endpackage

/* rtl/four_neighbor_peak_clip_filter.sv */
// A result goes from its request through the queue, the slot registers and the output register;
// a pixel of a row before the last is released by the request of the pixel below it.
// Throughput: one request per cycle and one result per cycle while the queue and output are not
// stalled; on the last row a request can make up to three results, so the output limits requests.
// The line store has one read and one write port, one column read ahead per request.
// Reset: frame size 1x1, position row 0 column 0, queue and output empty; line store undefined.
module four_neighbor_peak_clip_filter #(
    parameter int MAX_COLS    = npc_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS    = npc_pkg::DEF_MAX_ROWS,
    parameter int QUEUE_DEPTH = npc_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [npc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [npc_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [npc_pkg::PIX_W-1:0]       pixel_in,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [npc_pkg::PIX_W-1:0]       pixel_out,
    output logic                            frame_end
);

    logic             push_valid;
    logic             push_ready;
    npc_pkg::bundle_t push_data;
    logic             pop_valid;
    logic             pop_ready;
    npc_pkg::bundle_t pop_data;

    assign cfg_ready = 1'b1;

    npc_front #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .pixel_in   (pixel_in),
        .push_valid (push_valid),
        .push_data  (push_data),
        .push_ready (push_ready)
    );

    npc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    npc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .pixel_out (pixel_out),
        .frame_end (frame_end)
    );

endmodule

/* rtl/npc_ram.sv */
module npc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/npc_front.sv */
module npc_front #(
    parameter int MAX_COLS = npc_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = npc_pkg::DEF_MAX_ROWS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    input  logic [npc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [npc_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [npc_pkg::PIX_W-1:0]          pixel_in,
    output logic                               push_valid,
    output npc_pkg::bundle_t                   push_data,
    input  logic                               push_ready
);

    localparam int PW       = npc_pkg::PIX_W;
    localparam int COL_BITS = $clog2(MAX_COLS);
    localparam int COLS_W   = $clog2(MAX_COLS + 1);
    localparam int ROW_BITS = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int ROWS_W   = $clog2(MAX_ROWS + 1);

    typedef struct packed {
        logic [PW-1:0] older;
        logic [PW-1:0] newer;
    } pair_t;

    function automatic logic [PW-1:0] clip(
        input logic [PW-1:0]       ctr,
        input logic [3:0][PW-1:0]  nb,
        input logic [3:0]          ex
    );
        logic          peak;
        logic [PW-1:0] best;
        peak = 1'b1;
        best = '0;
        for (int i = 0; i < 4; i++)
        begin
            if (ex[i])
            begin
                if (ctr <= nb[i])
                begin
                    peak = 1'b0;
                end
                else if (nb[i] > best)
                begin
                    best = nb[i];
                end
            end
        end
        return peak ? best : ctr;
    endfunction

    logic [ROWS_W-1:0]   rows_cfg_reg, rows_cfg_next;
    logic [COLS_W-1:0]   cols_cfg_reg, cols_cfg_next;
    logic [ROW_BITS-1:0] row_reg, row_next;
    logic [COL_BITS-1:0] col_reg, col_next;
    logic                byp_reg, byp_next;
    pair_t               byp_data_reg, byp_data_next;
    pair_t               cur_reg, cur_next;
    pair_t               col0_reg, col0_next;
    logic [PW-1:0]       prev_mid_reg, prev_mid_next;
    logic [PW-1:0]       prior_reg, prior_next;
    logic [PW-1:0]       prior2_reg, prior2_next;

    logic [npc_pkg::ROWS_CFG_W-1:0] rows_raw;
    logic [npc_pkg::COLS_CFG_W-1:0] cols_raw;
    logic                accept;
    logic                cfg_hit;
    logic                last_col;
    logic                last_row;
    logic                row_ge1;
    logic                row_ge2;
    logic                col_ge1;
    logic                col_ge2;
    logic [COL_BITS-1:0] raddr;
    logic [2*PW-1:0]     ram_q;
    pair_t               nxt_eff;
    pair_t               wpair;
    logic [PW-1:0]       up_old;
    logic [PW-1:0]       mid;
    npc_pkg::bundle_t    bundle;

    assign in_ready = push_ready;
    assign accept   = in_valid && in_ready;

    assign rows_raw = cfg_data[npc_pkg::ROWS_CFG_W-1:0];
    assign cols_raw = cfg_data[npc_pkg::COLS_CFG_W-1:0];

    assign last_col = (COLS_W'(col_reg) + COLS_W'(1)) == cols_cfg_reg;
    assign last_row = (ROWS_W'(row_reg) + ROWS_W'(1)) == rows_cfg_reg;
    assign row_ge1  = row_reg != '0;
    assign row_ge2  = row_ge1 && (row_reg != ROW_BITS'(1));
    assign col_ge1  = col_reg != '0;
    assign col_ge2  = col_ge1 && (col_reg != COL_BITS'(1));

    assign nxt_eff  = byp_reg ? byp_data_reg : pair_t'(ram_q);
    assign up_old   = cur_reg.older;
    assign mid      = cur_reg.newer;
    assign wpair    = '{older: mid, newer: pixel_in};

    always_comb
    begin
        rows_cfg_next = rows_cfg_reg;
        cols_cfg_next = cols_cfg_reg;
        cfg_hit       = 1'b0;
        if (cfg_valid)
        begin
            case (cfg_index)
                npc_pkg::REG_FRAME_ROWS:
                begin
                    cfg_hit = 1'b1;
                    if (rows_raw == '0)
                        rows_cfg_next = ROWS_W'(1);
                    else if (32'(rows_raw) > 32'(MAX_ROWS))
                        rows_cfg_next = ROWS_W'(MAX_ROWS);
                    else
                        rows_cfg_next = ROWS_W'(rows_raw);
                end
                npc_pkg::REG_FRAME_COLS:
                begin
                    cfg_hit = 1'b1;
                    if (cols_raw == '0)
                        cols_cfg_next = COLS_W'(1);
                    else if (32'(cols_raw) > 32'(MAX_COLS))
                        cols_cfg_next = COLS_W'(MAX_COLS);
                    else
                        cols_cfg_next = COLS_W'(cols_raw);
                end
                default:
                begin
                    cfg_hit = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        row_next      = row_reg;
        col_next      = col_reg;
        cur_next      = cur_reg;
        col0_next     = col0_reg;
        prev_mid_next = prev_mid_reg;
        prior_next    = prior_reg;
        prior2_next   = prior2_reg;
        if (cfg_hit)
        begin
            row_next = '0;
            col_next = '0;
            cur_next = col0_reg;
        end
        else if (accept)
        begin
            prev_mid_next = mid;
            prior_next    = pixel_in;
            prior2_next   = prior_reg;
            if (!col_ge1)
                col0_next = wpair;
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + ROW_BITS'(1);
                cur_next = col_ge1 ? col0_reg : wpair;
            end
            else
            begin
                col_next = col_reg + COL_BITS'(1);
                cur_next = nxt_eff;
            end
        end
    end

    // keep the read port one column ahead of the next request
    assign raddr         = col_next + COL_BITS'(1);
    assign byp_next      = accept && (raddr == col_reg);
    assign byp_data_next = wpair;

    npc_ram #(
        .WIDTH (2 * PW),
        .DEPTH (MAX_COLS)
    ) u_line_ram (
        .clk   (clk),
        .we    (accept),
        .waddr (col_reg),
        .wdata (wpair),
        .raddr (raddr),
        .rdata (ram_q)
    );

    always_comb
    begin
        bundle = '0;
        bundle.valid[npc_pkg::SLOT_ABOVE] = row_ge1;
        bundle.pix[npc_pkg::SLOT_ABOVE]   = clip(mid,
            {nxt_eff.newer, prev_mid_reg, pixel_in, up_old},
            {!last_col, col_ge1, 1'b1, row_ge2});
        bundle.valid[npc_pkg::SLOT_LEFT]  = last_row && col_ge1;
        bundle.pix[npc_pkg::SLOT_LEFT]    = clip(prior_reg,
            {pixel_in, pixel_in, prior2_reg, prev_mid_reg},
            {1'b0, 1'b1, col_ge2, row_ge1});
        bundle.valid[npc_pkg::SLOT_FINAL] = last_row && last_col;
        bundle.pix[npc_pkg::SLOT_FINAL]   = clip(pixel_in,
            {prior_reg, prior_reg, prior_reg, mid},
            {1'b0, 1'b0, col_ge1, row_ge1});
    end

    assign push_valid = accept && (bundle.valid != '0);
    assign push_data  = bundle;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_cfg_reg <= ROWS_W'(1);
            cols_cfg_reg <= COLS_W'(1);
            row_reg      <= '0;
            col_reg      <= '0;
            byp_reg      <= 1'b0;
            prior_reg    <= '0;
        end
        else
        begin
            rows_cfg_reg <= rows_cfg_next;
            cols_cfg_reg <= cols_cfg_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            byp_reg      <= byp_next;
            prior_reg    <= prior_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byp_data_reg <= byp_data_next;
        cur_reg      <= cur_next;
        col0_reg     <= col0_next;
        prev_mid_reg <= prev_mid_next;
        prior2_reg   <= prior2_next;
    end

`ifndef NO_ASSERTIONS
    a_col_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        COLS_W'(col_reg) < cols_cfg_reg)
        else $error("column position beyond frame width");

    a_row_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        ROWS_W'(row_reg) < rows_cfg_reg)
        else $error("row position beyond frame height");

    a_push_on_request: assert property (@(posedge clk) disable iff (!rst_n)
        push_valid |-> (in_valid && push_ready))
        else $error("result bundle pushed without an accepted request");
`endif

endmodule

/* rtl/npc_queue.sv */
module npc_queue #(
    parameter int DEPTH = npc_pkg::DEF_QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  npc_pkg::bundle_t push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output npc_pkg::bundle_t pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    npc_pkg::bundle_t entries_reg [DEPTH];
    logic [PTR_W-1:0] wptr_reg, wptr_next;
    logic [PTR_W-1:0] rptr_reg, rptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = count_reg != CNT_W'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = entries_reg[rptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (do_push)
            wptr_next = (32'(wptr_reg) == DEPTH - 1) ? '0 : wptr_reg + PTR_W'(1);
        if (do_pop)
            rptr_next = (32'(rptr_reg) == DEPTH - 1) ? '0 : rptr_reg + PTR_W'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wptr_reg] <= push_data;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue occupancy beyond depth");
`endif

endmodule

/* rtl/npc_back.sv */
module npc_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      pop_valid,
    output logic                      pop_ready,
    input  npc_pkg::bundle_t          pop_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [npc_pkg::PIX_W-1:0] pixel_out,
    output logic                      frame_end
);

    localparam int NS = npc_pkg::NUM_SLOTS;
    localparam int PW = npc_pkg::PIX_W;

    logic [NS-1:0]          mask_reg, mask_next;
    logic [NS-1:0][PW-1:0]  vals_reg, vals_next;
    logic                   out_valid_reg, out_valid_next;
    logic [PW-1:0]          pixel_reg, pixel_next;
    logic                   end_reg, end_next;
    logic [NS-1:0]          remaining;
    npc_pkg::slot_t         sel;
    logic                   out_free;
    logic                   emit;
    logic                   take;

    always_comb
    begin
        sel = npc_pkg::SLOT_FINAL;
        if (mask_reg[npc_pkg::SLOT_ABOVE])
            sel = npc_pkg::SLOT_ABOVE;
        else if (mask_reg[npc_pkg::SLOT_LEFT])
            sel = npc_pkg::SLOT_LEFT;

        out_free  = !out_valid_reg || out_ready;
        emit      = out_free && (mask_reg != '0);
        remaining = mask_reg;
        if (emit)
            remaining[sel] = 1'b0;
        take      = pop_valid && (remaining == '0);

        mask_next = take ? pop_data.valid : remaining;
        vals_next = take ? pop_data.pix : vals_reg;

        out_valid_next = out_valid_reg;
        pixel_next     = pixel_reg;
        end_next       = end_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            pixel_next     = vals_reg[sel];
            end_next       = sel == npc_pkg::SLOT_FINAL;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign pop_ready = remaining == '0;
    assign out_valid = out_valid_reg;
    assign pixel_out = pixel_reg;
    assign frame_end = end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mask_reg      <= mask_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        vals_reg  <= vals_next;
        pixel_reg <= pixel_next;
        end_reg   <= end_next;
    end

`ifndef NO_ASSERTIONS
    a_emit_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(mask_reg != '0))
        else $error("result presented with no pending work");
`endif

endmodule
